// ===== rtl/core/tcce_pkg.sv =====
// Package for the TCP client connection engine: state, flag, status and request codes.
// Depends on nothing; used by tcp_client_connection_engine.
`default_nettype none
package tcce_pkg;
   localparam logic [1:0] FUNC_OPEN  = 2'd0;
   localparam logic [1:0] FUNC_SEND  = 2'd1;
   localparam logic [1:0] FUNC_CLOSE = 2'd2;
   localparam logic [1:0] FUNC_RECV  = 2'd3;

   localparam logic [7:0] FLAG_FIN = 8'h01;
   localparam logic [7:0] FLAG_SYN = 8'h02;
   localparam logic [7:0] FLAG_RST = 8'h04;
   localparam logic [7:0] FLAG_PSH = 8'h08;
   localparam logic [7:0] FLAG_ACK = 8'h10;

   localparam logic [2:0] ST_CLOSED     = 3'd0;
   localparam logic [2:0] ST_SYN_SENT   = 3'd1;
   localparam logic [2:0] ST_ESTAB      = 3'd2;
   localparam logic [2:0] ST_FIN_WAIT_1 = 3'd3;
   localparam logic [2:0] ST_FIN_WAIT_2 = 3'd4;
   localparam logic [2:0] ST_CLOSE_WAIT = 3'd5;
   localparam logic [2:0] ST_LAST_ACK   = 3'd6;
   localparam logic [2:0] ST_TIME_WAIT  = 3'd7;

   localparam logic [2:0] STS_OK        = 3'd0;
   localparam logic [2:0] STS_NO_SLOT   = 3'd1;
   localparam logic [2:0] STS_BAD_INDEX = 3'd2;
   localparam logic [2:0] STS_WRONG_ST  = 3'd3;
   localparam logic [2:0] STS_TOO_LONG  = 3'd4;
   localparam logic [2:0] STS_IGNORED   = 3'd5;

   localparam logic [1:0] CSR_LOCAL_ADDR = 2'd0;
   localparam logic [1:0] CSR_INIT_SEQ   = 2'd1;
   localparam logic [1:0] CSR_ADV_WIN    = 2'd2;

   localparam logic [15:0] PORT_BASE   = 16'd49152;
   localparam logic [31:0] ISN_RESET   = 32'h12345678;
   localparam logic [15:0] WIN_RESET   = 16'd4096;
   localparam logic [15:0] HDR_BYTES   = 16'd20;

   // one emitted word before packing
   typedef struct packed {
      logic        tx_valid;
      logic [2:0]  status;
      logic [2:0]  slot;
      logic [7:0]  tx_flags;
      logic [31:0] tx_seq;
      logic [31:0] tx_ack;
      logic [15:0] tx_sport;
      logic [15:0] tx_dport;
      logic [31:0] tx_dst_addr;
      logic [10:0] tx_payload_len;
      logic [2:0]  new_state;
      logic        last;
   } rsp_type;
endpackage
`default_nettype wire

// ===== rtl/core/tcp_client_connection_engine.sv =====
// TCP client connection engine: connection entries in one synchronous memory, slot states in registers; uses tcce_pkg.
// Flow: accept, slot choice (after a one-entry-a-cycle sweep over the memory for a received
// segment), read of the chosen entry, decision, then one result word per take on the result side.
// One request in flight: the next accept waits until the last result word is taken,
// so stalls on the result side hold it off.
// Reset: synchronous, active high; clears slot states and control, loads port counter and CSR registers.
`default_nettype none
module tcp_client_connection_engine #(
   parameter int NUM_SLOTS       = 8,
   parameter int TX_BUFFER_BYTES = 1500
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   // tdata from bit 0: conn_index[3], remote_addr[32], peer_port[16],
   // host_port[16], seg_flags[8], seg_seq[32], seg_ack[32], pay_len[16], pad 5
   input  wire logic [159:0] req_tdata,
   input  wire logic [1:0]   req_tuser,  // func
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   // tdata from bit 0: status[3], slot[3], tx_flags[8], tx_seq[32],
   // tx_ack[32], tx_sport[16], tx_dport[16], tx_dst_addr[32],
   // tx_payload_len[11], new_state[3], pad 4
   output logic [159:0]      rsp_tdata,
   output logic              rsp_tuser,  // tx_valid
   output logic              rsp_tlast,
   input  wire logic         csr_we,
   input  wire logic [1:0]   csr_index,
   input  wire logic [31:0]  csr_wdata
);
   import tcce_pkg::*;

   localparam int IW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
   localparam int CW = $clog2(NUM_SLOTS + 1);
   localparam logic [15:0] MAX_LEN = 16'(TX_BUFFER_BYTES - 20);

   // sequencer codes
   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_SRCH  = 4'd1;  // sweep reads over memory
   localparam logic [3:0] S_LOOK  = 4'd2;  // choose slot for the request
   localparam logic [3:0] S_EXEC  = 4'd3;  // read issued for chosen slot
   localparam logic [3:0] S_EMIT  = 4'd4;  // present word, wait for take
   localparam logic [3:0] S_DONE  = 4'd5;

   typedef struct packed {
      logic [31:0] raddr;
      logic [15:0] rport;
      logic [15:0] lport;
      logic [31:0] sseq;
      logic [31:0] rack;
   } entry_type;

   // connection memory, one read port registered
   entry_type mem [NUM_SLOTS];
   entry_type rd_ff;
   logic              mem_we;
   logic [IW-1:0]     mem_wa;
   entry_type         mem_wd;
   logic [IW-1:0]     mem_ra;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wa] <= mem_wd;
      end
      rd_ff <= mem[mem_ra];
   end

   logic [2:0]  st_ff [NUM_SLOTS];
   logic [31:0] laddr_ff, isn_ff;
   logic [15:0] win_ff;
   logic [15:0] port_ff;
   logic [3:0]  fsm_ff, fsm_in;
   logic [1:0]  func_ff;
   logic [159:0] req_ff;
   logic [CW-1:0] cnt_ff, cnt_in;       // sweep issue counter
   logic [CW-1:0] chk_ff, chk_in;       // index of entry now in rd_ff
   logic          chk_v_ff, chk_v_in;
   logic          hit_ff, hit_in;
   logic [IW-1:0] sel_ff, sel_in;
   rsp_type       words_ff [3], words_in [3];
   logic [1:0]    nw_ff, nw_in, wi_ff, wi_in;

   // request fields
   logic [2:0]  f_idx;
   logic [31:0] f_addr, f_seq, f_ack;
   logic [15:0] f_rport, f_lport, f_len;
   logic [7:0]  f_flags;
   assign f_idx   = req_ff[2:0];
   assign f_addr  = req_ff[34:3];
   assign f_rport = req_ff[50:35];
   assign f_lport = req_ff[66:51];
   assign f_flags = req_ff[74:67];
   assign f_seq   = req_ff[106:75];
   assign f_ack   = req_ff[138:107];
   assign f_len   = req_ff[154:139];

   function automatic rsp_type mk_status(logic [2:0] sts, logic [2:0] sl, logic [2:0] ns);
      rsp_type r;
      r = '0;
      r.status = sts;
      r.slot = sl;
      r.new_state = ns;
      return r;
   endfunction

   function automatic rsp_type mk_seg(entry_type e, logic [2:0] sl, logic [7:0] fl,
                                      logic [10:0] pl, logic [2:0] ns);
      rsp_type r;
      r = '0;
      r.tx_valid = 1'b1;
      r.slot = sl;
      r.tx_flags = fl;
      r.tx_seq = e.sseq;
      r.tx_ack = ((fl & FLAG_ACK) != 8'd0) ? e.rack : 32'd0;
      r.tx_sport = e.lport;
      r.tx_dport = e.rport;
      r.tx_dst_addr = e.raddr;
      r.tx_payload_len = pl;
      r.new_state = ns;
      return r;
   endfunction

   // state write-back request from the decide state (S_DONE)
   logic          st_we;
   logic [2:0]    st_wd;
   logic          port_inc;

   assign req_tready = (fsm_ff == S_IDLE);

   always_comb begin
      logic [2:0]  cur;
      logic [2:0]  sl3;
      logic [31:0] seq1;
      logic        fin;
      entry_type   e;
      fsm_in   = fsm_ff;
      cnt_in   = cnt_ff;
      chk_in   = chk_ff;
      chk_v_in = 1'b0;
      hit_in   = hit_ff;
      sel_in   = sel_ff;
      nw_in    = nw_ff;
      wi_in    = wi_ff;
      for (int k = 0; k < 3; k++) begin
         words_in[k] = words_ff[k];
      end
      mem_we   = 1'b0;
      mem_wa   = sel_ff;
      mem_wd   = rd_ff;
      mem_ra   = sel_ff;
      st_we    = 1'b0;
      st_wd    = ST_CLOSED;
      port_inc = 1'b0;
      cur      = st_ff[sel_ff];
      sl3      = 3'(sel_ff);
      seq1     = 32'd0;
      fin      = 1'b0;
      e        = rd_ff;
      unique case (fsm_ff)
         S_IDLE: begin
            cnt_in = '0;
            hit_in = 1'b0;
            wi_in  = 2'd0;
            if (req_tvalid) begin
               priority case (req_tuser)
                  FUNC_RECV: fsm_in = S_SRCH;
                  default:   fsm_in = S_LOOK;
               endcase
            end
         end
         S_SRCH: begin
            // issue one read a cycle, test the one that came back
            mem_ra = cnt_ff[IW-1:0];
            if (cnt_ff < CW'(NUM_SLOTS)) begin
               cnt_in   = cnt_ff + 1'b1;
               chk_v_in = 1'b1;
               chk_in   = cnt_ff;
            end
            if (chk_v_ff && !hit_ff && st_ff[chk_ff[IW-1:0]] != ST_CLOSED &&
                rd_ff.raddr == f_addr && rd_ff.rport == f_rport &&
                rd_ff.lport == f_lport) begin
               hit_in = 1'b1;
               sel_in = chk_ff[IW-1:0];
            end
            if (!chk_v_ff && cnt_ff == CW'(NUM_SLOTS)) begin
               fsm_in = S_LOOK;
            end
         end
         S_LOOK: begin
            if (func_ff == FUNC_OPEN) begin
               hit_in = 1'b0;
               for (int k = NUM_SLOTS - 1; k >= 0; k--) begin
                  if (st_ff[k] == ST_CLOSED) begin
                     hit_in = 1'b1;
                     sel_in = IW'(k);
                  end
               end
            end else if (func_ff != FUNC_RECV) begin
               sel_in = IW'(f_idx);
            end
            fsm_in = S_EXEC;
         end
         S_EXEC: begin
            mem_ra = sel_ff; // settle read of the chosen entry
            fsm_in = S_DONE;
         end
         S_DONE: begin
            fsm_in = S_EMIT;
            nw_in  = 2'd1;
            priority case (func_ff)
               FUNC_OPEN: begin
                  if (!hit_ff) begin
                     words_in[0] = mk_status(STS_NO_SLOT, 3'd0, ST_CLOSED);
                  end else begin
                     e.raddr = f_addr;
                     e.rport = f_rport;
                     e.lport = port_ff;
                     e.sseq  = isn_ff;
                     e.rack  = 32'd0;
                     words_in[0] = mk_seg(e, sl3, FLAG_SYN, 11'd0, ST_SYN_SENT);
                     e.sseq  = isn_ff + 32'd1;
                     mem_we = 1'b1; mem_wd = e;
                     st_we = 1'b1; st_wd = ST_SYN_SENT;
                     port_inc = 1'b1;
                  end
               end
               FUNC_SEND, FUNC_CLOSE: begin
                  if (32'(f_idx) >= 32'(NUM_SLOTS)) begin
                     words_in[0] = mk_status(STS_BAD_INDEX, f_idx, ST_CLOSED);
                  end else if (cur != ST_ESTAB) begin
                     words_in[0] = mk_status(STS_WRONG_ST, f_idx, cur);
                  end else if (func_ff == FUNC_SEND) begin
                     if (f_len > MAX_LEN) begin
                        words_in[0] = mk_status(STS_TOO_LONG, f_idx, ST_ESTAB);
                     end else begin
                        words_in[0] = mk_seg(e, f_idx, FLAG_ACK | FLAG_PSH,
                                             f_len[10:0], ST_ESTAB);
                        e.sseq = e.sseq + {16'd0, f_len};
                        mem_we = 1'b1; mem_wd = e;
                     end
                  end else begin
                     words_in[0] = mk_seg(e, f_idx, FLAG_FIN | FLAG_ACK, 11'd0,
                                          ST_FIN_WAIT_1);
                     e.sseq = e.sseq + 32'd1;
                     mem_we = 1'b1; mem_wd = e;
                     st_we = 1'b1; st_wd = ST_FIN_WAIT_1;
                  end
               end
               default: begin
                  fin  = (f_flags & FLAG_FIN) != 8'd0;
                  seq1 = f_seq + {16'd0, f_len};
                  nw_in = 2'd0;
                  if (!hit_ff) begin
                     words_in[0] = mk_status(STS_IGNORED, 3'd0, ST_CLOSED);
                     nw_in = 2'd1;
                  end else begin
                     unique case (cur)
                        ST_SYN_SENT: begin
                           if ((f_flags & (FLAG_SYN | FLAG_ACK)) == (FLAG_SYN | FLAG_ACK)) begin
                              e.rack = f_seq + 32'd1;
                              e.sseq = f_ack;
                              words_in[0] = mk_seg(e, sl3, FLAG_ACK, 11'd0, ST_ESTAB);
                              nw_in = 2'd1;
                              mem_we = 1'b1; mem_wd = e;
                              st_we = 1'b1; st_wd = ST_ESTAB;
                           end else if ((f_flags & FLAG_RST) != 8'd0) begin
                              words_in[0] = mk_status(STS_OK, sl3, ST_CLOSED);
                              nw_in = 2'd1;
                              st_we = 1'b1; st_wd = ST_CLOSED;
                           end
                        end
                        ST_ESTAB: begin
                           if ((f_flags & FLAG_RST) != 8'd0) begin
                              words_in[0] = mk_status(STS_OK, sl3, ST_CLOSED);
                              nw_in = 2'd1;
                              st_we = 1'b1; st_wd = ST_CLOSED;
                           end else begin
                              if (f_len != 16'd0) begin
                                 e.rack = seq1;
                                 words_in[0] = mk_seg(e, sl3, FLAG_ACK, 11'd0, ST_ESTAB);
                                 nw_in = 2'd1;
                              end
                              if (fin) begin
                                 e.rack = seq1 + 32'd1;
                                 words_in[nw_in] = mk_seg(e, sl3, FLAG_ACK, 11'd0,
                                                          ST_CLOSE_WAIT);
                                 words_in[nw_in + 2'd1] = mk_seg(e, sl3,
                                    FLAG_FIN | FLAG_ACK, 11'd0, ST_LAST_ACK);
                                 nw_in = nw_in + 2'd2;
                                 e.sseq = e.sseq + 32'd1;
                                 st_we = 1'b1; st_wd = ST_LAST_ACK;
                              end
                              mem_we = 1'b1; mem_wd = e;
                           end
                        end
                        ST_FIN_WAIT_1: begin
                           if ((f_flags & FLAG_ACK) != 8'd0) begin
                              words_in[0] = mk_status(STS_OK, sl3, ST_FIN_WAIT_2);
                              nw_in = 2'd1;
                              st_we = 1'b1; st_wd = ST_FIN_WAIT_2;
                           end
                        end
                        ST_FIN_WAIT_2: begin
                           if (fin) begin
                              e.rack = seq1 + 32'd1;
                              words_in[0] = mk_seg(e, sl3, FLAG_ACK, 11'd0, ST_CLOSED);
                              nw_in = 2'd1;
                              mem_we = 1'b1; mem_wd = e;
                              st_we = 1'b1; st_wd = ST_CLOSED;
                           end
                        end
                        ST_LAST_ACK: begin
                           if ((f_flags & FLAG_ACK) != 8'd0) begin
                              words_in[0] = mk_status(STS_OK, sl3, ST_CLOSED);
                              nw_in = 2'd1;
                              st_we = 1'b1; st_wd = ST_CLOSED;
                           end
                        end
                        default: ;
                     endcase
                     if (nw_in == 2'd0) begin
                        words_in[0] = mk_status(STS_IGNORED, sl3, cur);
                        nw_in = 2'd1;
                     end
                  end
               end
            endcase
         end
         S_EMIT: begin
            // advance one word per take
            if (rsp_tready) begin
               if (wi_ff + 2'd1 == nw_ff) begin
                  fsm_in = S_IDLE;
               end
               wi_in = wi_ff + 2'd1;
            end
         end
         default: fsm_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fsm_ff   <= S_IDLE;
         port_ff  <= PORT_BASE;
         laddr_ff <= 32'd0;
         isn_ff   <= ISN_RESET;
         win_ff   <= WIN_RESET;
         chk_v_ff <= 1'b0;
         for (int k = 0; k < NUM_SLOTS; k++) begin
            st_ff[k] <= ST_CLOSED;
         end
      end else begin
         fsm_ff   <= fsm_in;
         chk_v_ff <= chk_v_in;
         if (port_inc) begin
            port_ff <= port_ff + 16'd1;
         end
         if (st_we) begin
            st_ff[sel_ff] <= st_wd;
         end
         if (csr_we) begin
            unique case (csr_index)
               CSR_LOCAL_ADDR: laddr_ff <= csr_wdata;
               CSR_INIT_SEQ:   isn_ff   <= csr_wdata;
               CSR_ADV_WIN:    win_ff   <= csr_wdata[15:0];
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         req_ff  <= req_tdata;
         func_ff <= req_tuser;
      end
      cnt_ff <= cnt_in;
      chk_ff <= chk_in;
      hit_ff <= hit_in;
      sel_ff <= sel_in;
      nw_ff  <= nw_in;
      wi_ff  <= wi_in;
      for (int k = 0; k < 3; k++) begin
         words_ff[k] <= words_in[k];
      end
   end

   // output word; address and window only feed the (absent) header builder
   rsp_type cur_w;
   logic    unused_ok;
   assign cur_w      = words_ff[wi_ff];
   assign unused_ok  = ^{laddr_ff, win_ff};
   assign rsp_tvalid = (fsm_ff == S_EMIT);
   assign rsp_tlast  = (wi_ff + 2'd1 == nw_ff);
   assign rsp_tuser  = cur_w.tx_valid ^ (unused_ok & 1'b0);
   assign rsp_tdata  = {4'd0, cur_w.new_state, cur_w.tx_payload_len, cur_w.tx_dst_addr,
                        cur_w.tx_dport, cur_w.tx_sport, cur_w.tx_ack,
                        cur_w.tx_seq, cur_w.tx_flags, cur_w.slot, cur_w.status};

`ifndef SYNTHESIS
   a_rdy_idle: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> !rsp_tvalid) else $error("ready while emitting");
   a_nw: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (nw_ff != 2'd0)) else $error("emit with no words");
   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tready && rsp_tlast) |=> req_tready)
      else $error("no return to idle after last word");
   a_status_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tuser) |-> (rsp_tdata[152:6] == '0))
      else $error("status word carries segment fields");
`endif
endmodule
`default_nettype wire
